>>> sv/dsd_pkg.sv
// Shared types and constants for the DDS sine DAC sample generator.
// Holds the polynomial coefficients, reset values, register indexes and the
// controller/datapath command types. No dependencies.
package dsd_pkg;

    // Default parameter values
    localparam int PHASE_BITS_DEF = 32;
    localparam int SINE_BITS_DEF  = 16;
    localparam int DAC_BITS_DEF   = 12;

    // Configuration port widths
    localparam int CFG_IDX_BITS  = 2;
    localparam int CFG_DATA_BITS = 32;
    localparam int GAIN_BITS     = 16;

    // Register reset values
    localparam logic [31:0]          PHASE_STEP_RST  = 32'd2236962;
    localparam logic [31:0]          START_PHASE_RST = 32'd3611402020;
    localparam logic [GAIN_BITS-1:0] AMP_GAIN_RST    = 16'd63570;

    // Q30 sine polynomial coefficients
    localparam logic [31:0] COEF_1 = 32'd1686629713;
    localparam logic [31:0] COEF_3 = 32'd693598668;
    localparam logic [31:0] COEF_5 = 32'd85569305;
    localparam logic [31:0] COEF_7 = 32'd5026994;
    localparam logic [31:0] COEF_9 = 32'd172272;
    localparam logic [31:0] Q30_ONE = 32'h4000_0000;

    // Register indexes on the configuration port
    typedef enum logic [CFG_IDX_BITS-1:0] {
        REG_PHASE_STEP  = 2'd0,
        REG_START_PHASE = 2'd1,
        REG_AMP_GAIN    = 2'd2
    } cfg_idx_t;

    // Datapath operations, one per controller step
    typedef enum logic [3:0] {
        OP_NONE,
        OP_SQR,
        OP_MUL_C9,
        OP_SUB_C7,
        OP_SUB_C5,
        OP_SUB_C3,
        OP_SUB_C1,
        OP_MUL_S,
        OP_MUL_XS,
        OP_ROUND,
        OP_GAIN,
        OP_LOAD_OUT
    } op_t;

    // Controller states
    typedef enum logic [3:0] {
        S_IDLE,
        S_SQR,
        S_C9,
        S_SUB7,
        S_MUL7,
        S_SUB5,
        S_MUL5,
        S_SUB3,
        S_MUL3,
        S_SUB1,
        S_MULX,
        S_ROUND,
        S_GAIN,
        S_FINAL
    } state_t;

    // Command from controller to datapath
    typedef struct packed {
        logic load_phase;
        op_t  op;
    } cmd_t;

endpackage

>>> sv/dsd_if.sv
// Channel interfaces for the DDS sine DAC sample generator: tick input,
// DAC code output and configuration write channel. Uses dsd_pkg widths.
interface dsd_tick_if;
    logic valid;
    logic ready;
    logic tick;

    modport source (output valid, output tick, input ready);
    modport sink   (input valid, input tick, output ready);
endinterface

interface dsd_dac_if #(
    parameter int DAC_BITS = dsd_pkg::DAC_BITS_DEF
);
    logic                valid;
    logic                ready;
    logic [DAC_BITS-1:0] dac_code;

    modport source (output valid, output dac_code, input ready);
    modport sink   (input valid, input dac_code, output ready);
endinterface

interface dsd_cfg_if;
    logic                               valid;
    logic                               ready;
    logic [dsd_pkg::CFG_IDX_BITS-1:0]   index;
    logic [dsd_pkg::CFG_DATA_BITS-1:0]  data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

>>> sv/dsd_ctrl.sv
// Controller state machine for the DDS sine DAC sample generator.
// Sequences the datapath through the polynomial steps; depends on dsd_pkg.
module dsd_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    input  logic           in_tick,
    output logic           in_ready,
    output logic           out_valid,
    input  logic           out_ready,
    output dsd_pkg::cmd_t  cmd
);
    import dsd_pkg::*;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   slot_free;
    logic   start;

    assign slot_free = !out_valid_reg || out_ready;
    assign start     = (state_reg == S_IDLE) && in_valid && in_tick;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:  if (start) state_next = S_SQR;
            S_SQR:   state_next = S_C9;
            S_C9:    state_next = S_SUB7;
            S_SUB7:  state_next = S_MUL7;
            S_MUL7:  state_next = S_SUB5;
            S_SUB5:  state_next = S_MUL5;
            S_MUL5:  state_next = S_SUB3;
            S_SUB3:  state_next = S_MUL3;
            S_MUL3:  state_next = S_SUB1;
            S_SUB1:  state_next = S_MULX;
            S_MULX:  state_next = S_ROUND;
            S_ROUND: state_next = S_GAIN;
            S_GAIN:  state_next = S_FINAL;
            S_FINAL: if (slot_free) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    // Outputs: datapath command and handshakes
    always_comb
    begin
        cmd.load_phase = start;
        cmd.op         = OP_NONE;
        in_ready       = (state_reg == S_IDLE);
        case (state_reg)
            S_SQR:   cmd.op = OP_SQR;
            S_C9:    cmd.op = OP_MUL_C9;
            S_SUB7:  cmd.op = OP_SUB_C7;
            S_MUL7:  cmd.op = OP_MUL_S;
            S_SUB5:  cmd.op = OP_SUB_C5;
            S_MUL5:  cmd.op = OP_MUL_S;
            S_SUB3:  cmd.op = OP_SUB_C3;
            S_MUL3:  cmd.op = OP_MUL_S;
            S_SUB1:  cmd.op = OP_SUB_C1;
            S_MULX:  cmd.op = OP_MUL_XS;
            S_ROUND: cmd.op = OP_ROUND;
            S_GAIN:  cmd.op = OP_GAIN;
            S_FINAL: cmd.op = slot_free ? OP_LOAD_OUT : OP_NONE;
            default: cmd.op = OP_NONE;
        endcase
    end

    // Output slot: set on load, drop once taken
    always_comb
    begin
        if (cmd.op == OP_LOAD_OUT)
            out_valid_next = 1'b1;
        else
            out_valid_next = out_valid_reg && !out_ready;
    end

    assign out_valid = out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

>>> sv/dsd_datapath.sv
// Datapath for the DDS sine DAC sample generator: configuration registers,
// phase accumulator, shared 32x32 multiplier and DAC scaling. Uses dsd_pkg.
module dsd_datapath #(
    parameter int PHASE_BITS = dsd_pkg::PHASE_BITS_DEF,
    parameter int SINE_BITS  = dsd_pkg::SINE_BITS_DEF,
    parameter int DAC_BITS   = dsd_pkg::DAC_BITS_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_write,
    input  logic [dsd_pkg::CFG_IDX_BITS-1:0]   cfg_index,
    input  logic [dsd_pkg::CFG_DATA_BITS-1:0]  cfg_data,
    input  dsd_pkg::cmd_t                      cmd,
    output logic [DAC_BITS-1:0]                dac_code
);
    import dsd_pkg::*;

    localparam int FBITS  = PHASE_BITS - 2;
    localparam int SH     = 31 - SINE_BITS;
    localparam int QW     = SINE_BITS - 1;
    localparam int FB     = SINE_BITS - 1 + 16;
    localparam int WIDE_W = 80;
    localparam logic [SINE_BITS:0] Q_LIM = {2'b00, {(SINE_BITS-1){1'b1}}};
    localparam logic [31:0] HALF = 32'(1) << (SH - 1);
    localparam logic [WIDE_W-1:0] START_WIDE_RST = {START_PHASE_RST, 48'd0};

    logic [31:0]           step_reg;
    logic [GAIN_BITS-1:0]  gain_reg;
    logic [PHASE_BITS-1:0] acc_reg;
    logic [1:0]            quad_reg;
    logic [30:0]           x_reg;
    logic [31:0]           x2_reg;
    logic [31:0]           s_reg;
    logic [63:0]           p_reg;
    logic [QW-1:0]         q_reg;
    logic [DAC_BITS-1:0]   code_reg;

    logic [WIDE_W-1:0]      step_wide;
    logic [WIDE_W-1:0]      start_wide;
    logic [PHASE_BITS-1:0]  step_al;
    logic [PHASE_BITS-1:0]  start_al;
    logic [PHASE_BITS-1:0]  phase_new;
    logic [PHASE_BITS+43:0] r_wide;
    logic [29:0]            x_frac;
    logic [30:0]            x_new;
    logic [31:0]            p_q30;
    logic [31:0]            mul_a;
    logic [31:0]            mul_b;
    logic [63:0]            mul_p;
    logic [31:0]            coef;
    logic [31:0]            m_clamp;
    logic [31:0]            m_round;
    logic [SINE_BITS:0]     q_raw;
    logic [QW-1:0]          q_new;
    logic [FB:0]            num;
    logic [FB+DAC_BITS-1:0] scaled;

    // Align 32-bit turn fractions to the accumulator width
    assign step_wide  = {step_reg, 48'd0};
    assign start_wide = {cfg_data, 48'd0};
    assign step_al    = step_wide[WIDE_W-1 -: PHASE_BITS];
    assign start_al   = start_wide[WIDE_W-1 -: PHASE_BITS];

    // Advance phase, split quadrant and fold to a Q30 quarter-turn fraction
    assign phase_new = acc_reg + step_al;
    assign r_wide    = {phase_new[FBITS-1:0], 46'd0};
    assign x_frac    = r_wide[PHASE_BITS+43 -: 30];
    assign x_new     = phase_new[FBITS] ? (Q30_ONE[30:0] - {1'b0, x_frac})
                                        : {1'b0, x_frac};

    assign p_q30 = p_reg[61:30];

    // Select operands for the shared multiplier
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (cmd.op)
            OP_SQR:
            begin
                mul_a = {1'b0, x_reg};
                mul_b = {1'b0, x_reg};
            end
            OP_MUL_C9:
            begin
                mul_a = p_q30;
                mul_b = COEF_9;
            end
            OP_MUL_S:
            begin
                mul_a = x2_reg;
                mul_b = s_reg;
            end
            OP_MUL_XS:
            begin
                mul_a = {1'b0, x_reg};
                mul_b = s_reg;
            end
            OP_GAIN:
            begin
                mul_a = 32'(q_reg);
                mul_b = {16'd0, gain_reg};
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p = mul_a * mul_b;

    // Pick the Horner coefficient for a subtract step
    always_comb
    begin
        case (cmd.op)
            OP_SUB_C7: coef = COEF_7;
            OP_SUB_C5: coef = COEF_5;
            OP_SUB_C3: coef = COEF_3;
            OP_SUB_C1: coef = COEF_1;
            default:   coef = '0;
        endcase
    end

    // Clamp magnitude to one, round half up and limit to the sine range
    always_comb
    begin
        m_clamp = (p_q30 > Q30_ONE) ? Q30_ONE : p_q30;
        m_round = m_clamp + HALF;
        q_raw   = m_round[31:SH];
        q_new   = (q_raw > Q_LIM) ? Q_LIM[QW-1:0] : q_raw[QW-1:0];
    end

    // Offset by one and scale by 2^(DAC_BITS-1)-1 as shift and subtract
    always_comb
    begin
        if (quad_reg[1])
            num = {1'b1, {FB{1'b0}}} - {1'b0, p_reg[FB-1:0]};
        else
            num = {1'b1, {FB{1'b0}}} + {1'b0, p_reg[FB-1:0]};
        scaled = {num, {(DAC_BITS-1){1'b0}}} - {{(DAC_BITS-1){1'b0}}, num};
    end

    // Configuration registers and phase accumulator
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= PHASE_STEP_RST;
            gain_reg <= AMP_GAIN_RST;
            acc_reg  <= START_WIDE_RST[WIDE_W-1 -: PHASE_BITS];
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_PHASE_STEP:  step_reg <= cfg_data;
                REG_START_PHASE: acc_reg  <= start_al;
                REG_AMP_GAIN:    gain_reg <= cfg_data[GAIN_BITS-1:0];
                default:         ;
            endcase
        end
        else if (cmd.load_phase)
        begin
            acc_reg <= phase_new;
        end
    end

    // Working registers of the sine and scaling steps
    always_ff @(posedge clk)
    begin
        if (cmd.load_phase)
        begin
            quad_reg <= phase_new[PHASE_BITS-1:PHASE_BITS-2];
            x_reg    <= x_new;
        end
        if (cmd.op inside {OP_SQR, OP_MUL_C9, OP_MUL_S, OP_MUL_XS, OP_GAIN})
            p_reg <= mul_p;
        if (cmd.op == OP_MUL_C9)
            x2_reg <= p_q30;
        if (cmd.op inside {OP_SUB_C7, OP_SUB_C5, OP_SUB_C3, OP_SUB_C1})
            s_reg <= coef - p_q30;
        if (cmd.op == OP_ROUND)
            q_reg <= q_new;
        if (cmd.op == OP_LOAD_OUT)
            code_reg <= scaled[FB+DAC_BITS-1:FB];
    end

    assign dac_code = code_reg;

endmodule

>>> sv/dds_sine_dac_sample.sv
// Top level of the DDS sine DAC sample generator: joins controller and
// datapath to the channels. Depends on dsd_pkg, dsd_if, dsd_ctrl, dsd_datapath.
//
//   channel   dir   payload              handshake
//   tick_ch   in    tick (1 bit)         valid/ready
//   dac_ch    out   dac_code (DAC_BITS)  valid/ready
//   cfg_ch    in    index, data          valid/ready, always ready
//
// A tick of one is accepted in idle and then runs thirteen controller steps
// around one shared 32x32 multiplier (seven products, four subtracts,
// rounding and scaling). Its code is loaded in the final step and becomes
// valid after that load; the next tick is taken once the controller is idle.
// A tick of zero is accepted in idle, leaves the input open and gives no code.
// Reset loads the start phase into the accumulator; no clearing pass.
// A code waiting on dac_ch does not block the next tick; the final step holds
// until the output register is free.
module dds_sine_dac_sample #(
    parameter int PHASE_BITS = dsd_pkg::PHASE_BITS_DEF,
    parameter int SINE_BITS  = dsd_pkg::SINE_BITS_DEF,
    parameter int DAC_BITS   = dsd_pkg::DAC_BITS_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    dsd_tick_if.sink      tick_ch,
    dsd_dac_if.source     dac_ch,
    dsd_cfg_if.sink       cfg_ch
);
    import dsd_pkg::*;

    cmd_t cmd;
    logic cfg_write;

    // Configuration writes are always taken
    assign cfg_ch.ready = 1'b1;
    assign cfg_write    = cfg_ch.valid;

    dsd_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (tick_ch.valid),
        .in_tick   (tick_ch.tick),
        .in_ready  (tick_ch.ready),
        .out_valid (dac_ch.valid),
        .out_ready (dac_ch.ready),
        .cmd       (cmd)
    );

    dsd_datapath #(
        .PHASE_BITS (PHASE_BITS),
        .SINE_BITS  (SINE_BITS),
        .DAC_BITS   (DAC_BITS)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_ch.index),
        .cfg_data  (cfg_ch.data),
        .cmd       (cmd),
        .dac_code  (dac_ch.dac_code)
    );

    // A sample request closes the input until its code is built
    a_busy_after_tick: assert property (@(posedge clk) disable iff (!rst_n)
        tick_ch.valid && tick_ch.ready && tick_ch.tick |=> !tick_ch.ready)
        else $error("input still open after a sample request");

    // An idle tick leaves the input open
    a_idle_tick: assert property (@(posedge clk) disable iff (!rst_n)
        tick_ch.valid && tick_ch.ready && !tick_ch.tick |=> tick_ch.ready)
        else $error("idle tick closed the input");

    // Loading the output register raises the output valid
    a_load_valid: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.op == OP_LOAD_OUT |=> dac_ch.valid)
        else $error("output load without valid");

    // Output is loaded only into a free slot
    a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.op == OP_LOAD_OUT |-> !dac_ch.valid || dac_ch.ready)
        else $error("output overwritten while waiting");

endmodule
